// File: hdl/homogeneous_point_transform_assert.svh
// Assertion macros used by the checker file hpt_checker.sv.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HPT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("homogeneous_point_transform: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HPT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("homogeneous_point_transform: assertion failed");

`endif

// File: hdl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Types, constants, the divider step function and the saturation function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    localparam int ROW_LAT   = 5;
    localparam int DIV_STEPS = 80;
    localparam int NUM_LANES = 3;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OUTX_XY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTX_ZC = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTY_XY = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTY_ZC = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTZ_XY = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTZ_ZC = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTW_XY = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUTW_ZC = 4'd7;

    localparam logic [63:0] ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ONE_HIGH = 64'h0001_0000_0000_0000;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // one row of the matrix, reduced to sign and magnitude
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [63:0] mag;
        logic [31:0] zres;   // saturated result for the undivided case
    } row_res_t;

    // one divider lane
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] num;
        logic [30:0] quo;
        logic        ovf;    // quotient reached 2^31
        logic        neg;
        logic [31:0] zres;
    } div_lane_t;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic        wz;
    } result_t;

    function automatic logic [31:0] sat_q16(input logic neg, input logic ovf,
                                            input logic [30:0] q);
        logic [31:0] m;
        m = {1'b0, q};
        if (!neg)
            sat_q16 = ovf ? SAT_MAX : m;
        else
            sat_q16 = ovf ? SAT_MIN : (32'd0 - m);
    endfunction

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(input div_lane_t l, input logic [63:0] d);
        div_lane_t   o;
        logic [64:0] rs;
        logic        qb;
        o  = l;
        rs = {l.rem, l.num[63]};
        qb = (rs >= {1'b0, d});
        o.rem = qb ? (rs[63:0] - d) : rs[63:0];
        o.num = {l.num[62:0], 1'b0};
        o.ovf = l.ovf | l.quo[30];
        o.quo = {l.quo[29:0], qb};
        return o;
    endfunction

endpackage

`default_nettype wire

// File: hdl/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 Q16.16 point transform with perspective divide and saturation.
// ----------------------------------------------------------------------------
// One point (x, y, z) per item, taken with w = 1, is multiplied by the matrix
// in the eight coefficient registers; x', y', z' are then divided by w' and
// saturated to Q16.16. Where w' is exactly zero the undivided values
// (arithmetic shift by 16, saturated) pass and tuser is raised. One item is
// taken every clock unless the skid entry is full, and passes through five
// stages of multiply-accumulate, eighty stages of the bit-per-stage divider
// (the 80-bit scaled dividend sets that count), one select stage and the
// output register. A single skid entry behind the output register absorbs the
// item in flight when the sink stalls. Reset gives the identity matrix;
// coefficients should be written only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module homogeneous_point_transform
    import hpt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [95:0]          s_tdata,   // in_x, in_y, in_z
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [95:0]               m_tdata,   // out_x, out_y, out_z
    output logic                      m_tuser    // w_was_zero
);

    // coefficient registers, low word in bits 31:0
    logic [63:0] outx_xy_reg, outx_zc_reg, outy_xy_reg, outy_zc_reg;
    logic [63:0] outz_xy_reg, outz_zc_reg, outw_xy_reg, outw_zc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outx_xy_reg <= ONE_LOW;
            outx_zc_reg <= '0;
            outy_xy_reg <= ONE_HIGH;
            outy_zc_reg <= '0;
            outz_xy_reg <= '0;
            outz_zc_reg <= ONE_LOW;
            outw_xy_reg <= '0;
            outw_zc_reg <= ONE_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUTX_XY: outx_xy_reg <= cfg_data;
                REG_OUTX_ZC: outx_zc_reg <= cfg_data;
                REG_OUTY_XY: outy_xy_reg <= cfg_data;
                REG_OUTY_ZC: outy_zc_reg <= cfg_data;
                REG_OUTZ_XY: outz_xy_reg <= cfg_data;
                REG_OUTZ_ZC: outz_zc_reg <= cfg_data;
                REG_OUTW_XY: outw_xy_reg <= cfg_data;
                REG_OUTW_ZC: outw_zc_reg <= cfg_data;
                default: ;   // indexes past the list are dropped
            endcase
        end
    end

    // whole pipeline advances together; only a full skid entry holds it
    logic ce;
    assign s_tready = ce;

    logic signed [31:0] in_x, in_y, in_z;
    assign in_x = s_tdata[31:0];
    assign in_y = s_tdata[63:32];
    assign in_z = s_tdata[95:64];

    // valid bits alongside the row stages
    logic v_row_reg [ROW_LAT];

    for (genvar s = 0; s < ROW_LAT; s++)
    begin : g_vrow
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_row_reg[s] <= 1'b0;
            else if (ce)
                v_row_reg[s] <= (s == 0) ? s_tvalid : v_row_reg[(s == 0) ? 0 : s - 1];
        end
    end

    row_res_t rx, ry, rz, rw;

    hpt_row u_row_x (.clk, .ce, .x(in_x), .y(in_y), .z(in_z),
                     .xy_coef(outx_xy_reg), .zc_coef(outx_zc_reg), .res(rx));
    hpt_row u_row_y (.clk, .ce, .x(in_x), .y(in_y), .z(in_z),
                     .xy_coef(outy_xy_reg), .zc_coef(outy_zc_reg), .res(ry));
    hpt_row u_row_z (.clk, .ce, .x(in_x), .y(in_y), .z(in_z),
                     .xy_coef(outz_xy_reg), .zc_coef(outz_zc_reg), .res(rz));
    hpt_row u_row_w (.clk, .ce, .x(in_x), .y(in_y), .z(in_z),
                     .xy_coef(outw_xy_reg), .zc_coef(outw_zc_reg), .res(rw));

    logic    div_valid;
    result_t div_out;

    hpt_div u_div (
        .clk, .rst_n, .ce,
        .in_valid (v_row_reg[ROW_LAT-1]),
        .rx, .ry, .rz, .rw,
        .out_valid(div_valid),
        .out      (div_out)
    );

    result_t res;

    hpt_skid u_skid (
        .clk, .rst_n,
        .in_valid (div_valid),
        .in_data  (div_out),
        .ce,
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res)
    );

    assign m_tdata = {res.z, res.y, res.x};
    assign m_tuser = res.wz;

endmodule

`default_nettype wire

// File: hdl/hpt_row.sv
// ----------------------------------------------------------------------------
// hpt_row
// One matrix row: a*x + b*y + c*z + d in Q32.32, five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_row
    import hpt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               ce,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    input  wire logic signed [31:0] z,
    input  wire logic        [63:0] xy_coef,
    input  wire logic        [63:0] zc_coef,
    output row_res_t                res
);

    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [64:0] a01_reg, a23_reg;
    logic signed [65:0] sum_reg;
    logic               neg_reg;
    logic        [63:0] mag_reg;
    row_res_t           res_reg;

    logic        [63:0] t3_next;
    logic        [64:0] qr;
    logic        [48:0] qz;
    row_res_t           res_next;

    assign t3_next = {{16{zc_coef[63]}}, zc_coef[63:32], 16'd0};

    always_comb
    begin
        qr = {1'b0, mag_reg} + 65'h0_0000_0000_0000_FFFF;
        qz = neg_reg ? qr[64:16] : {1'b0, mag_reg[63:16]};
        res_next.neg  = neg_reg;
        res_next.zero = (mag_reg == 64'd0);
        res_next.mag  = mag_reg;
        res_next.zres = sat_q16(neg_reg, |qz[48:31], qz[30:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t0_reg  <= x * $signed(xy_coef[31:0]);
            t1_reg  <= y * $signed(xy_coef[63:32]);
            t2_reg  <= z * $signed(zc_coef[31:0]);
            t3_reg  <= $signed(t3_next);
            a01_reg <= {t0_reg[63], t0_reg} + {t1_reg[63], t1_reg};
            a23_reg <= {t2_reg[63], t2_reg} + {t3_reg[63], t3_reg};
            sum_reg <= {a01_reg[64], a01_reg} + {a23_reg[64], a23_reg};
            neg_reg <= sum_reg[65];
            mag_reg <= sum_reg[65] ? (64'd0 - sum_reg[63:0]) : sum_reg[63:0];
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: hdl/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider, three lanes sharing w, one bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_div
    import hpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic ce,
    input  wire logic in_valid,
    input  row_res_t  rx,
    input  row_res_t  ry,
    input  row_res_t  rz,
    input  row_res_t  rw,
    output logic      out_valid,
    output result_t   out
);

    div_lane_t   lane_reg [DIV_STEPS][NUM_LANES];
    logic [63:0] d_reg    [DIV_STEPS];
    logic        wz_reg   [DIV_STEPS];
    logic        v_reg    [DIV_STEPS];
    logic        out_valid_reg;
    result_t     out_reg;

    div_lane_t   init [NUM_LANES];
    result_t     out_next;

    always_comb
    begin
        init[0] = '{rem: '0, num: rx.mag, quo: '0, ovf: 1'b0,
                    neg: rx.neg ^ rw.neg, zres: rx.zres};
        init[1] = '{rem: '0, num: ry.mag, quo: '0, ovf: 1'b0,
                    neg: ry.neg ^ rw.neg, zres: ry.zres};
        init[2] = '{rem: '0, num: rz.mag, quo: '0, ovf: 1'b0,
                    neg: rz.neg ^ rw.neg, zres: rz.zres};
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ce)
                v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s - 1];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (s == 0)
                begin
                    d_reg[s]  <= rw.mag;
                    wz_reg[s] <= rw.zero;
                end
                else
                begin
                    d_reg[s]  <= d_reg[(s == 0) ? 0 : s - 1];
                    wz_reg[s] <= wz_reg[(s == 0) ? 0 : s - 1];
                end
            end
        end

        for (genvar k = 0; k < NUM_LANES; k++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (s == 0)
                        lane_reg[s][k] <= div_step(init[k], rw.mag);
                    else
                        lane_reg[s][k] <= div_step(lane_reg[(s == 0) ? 0 : s - 1][k],
                                                   d_reg[(s == 0) ? 0 : s - 1]);
                end
            end
        end
    end

    always_comb
    begin
        out_next.wz = wz_reg[DIV_STEPS-1];
        out_next.x  = wz_reg[DIV_STEPS-1] ? lane_reg[DIV_STEPS-1][0].zres :
                      sat_q16(lane_reg[DIV_STEPS-1][0].neg, lane_reg[DIV_STEPS-1][0].ovf,
                              lane_reg[DIV_STEPS-1][0].quo);
        out_next.y  = wz_reg[DIV_STEPS-1] ? lane_reg[DIV_STEPS-1][1].zres :
                      sat_q16(lane_reg[DIV_STEPS-1][1].neg, lane_reg[DIV_STEPS-1][1].ovf,
                              lane_reg[DIV_STEPS-1][1].quo);
        out_next.z  = wz_reg[DIV_STEPS-1] ? lane_reg[DIV_STEPS-1][2].zres :
                      sat_q16(lane_reg[DIV_STEPS-1][2].neg, lane_reg[DIV_STEPS-1][2].ovf,
                              lane_reg[DIV_STEPS-1][2].quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= v_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

`default_nettype wire

// File: hdl/hpt_skid.sv
// ----------------------------------------------------------------------------
// hpt_skid
// Output register plus one skid entry; stalls the pipeline when the skid fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpt_skid
    import hpt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  result_t   in_data,
    output logic      ce,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    out_free;

    assign ce       = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (out_free)
            out_valid_reg <= in_valid;
        else if (in_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (out_free)
            out_data_reg <= in_data;
        else
            skid_data_reg <= in_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks on the output stall path, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "homogeneous_point_transform_assert.svh"

module hpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic        m_tuser
);

    // a held result stays put
    `HPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // input side only stops while a result is waiting
    `HPT_ASSERT_NOW(a_stall_needs_result, !s_tready, m_tvalid)

    // the skid only fills on a refused result
    `HPT_ASSERT_NOW(a_stall_cause, $fell(s_tready), $past(m_tvalid && !m_tready))

    // one taken result frees the input side again
    `HPT_ASSERT_NEXT(a_stall_release, !s_tready && m_tready, s_tready)

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .clk, .rst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

`default_nettype wire
